@@ sv/sorted_key_table_engine_assert.svh @@
// Assertion macros for the sorted key table engine.
`ifndef SORTED_KEY_TABLE_ENGINE_ASSERT_SVH
`define SORTED_KEY_TABLE_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SKT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SKT_ASSERT_NOW(label, ante, cons, msg)
`define SKT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ sv/skt_pkg.sv @@
// Shared types and constants of the sorted key table engine.
package skt_pkg;

  // Widths of the fixed fields.
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int POSITION_W = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_LOOKUP = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_READ   = 3'd3,
    MODE_POP    = 3'd4,
    MODE_CLEAR  = 3'd5,
    MODE_ALLOC  = 3'd6
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD       = 3'd4
  } result_code_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_DESC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIQUE     = 1'b1;

  // Shift command broadcast to the row of cells.
  typedef struct packed {
    logic ins;  // open a slot at the index and write the new pair there
    logic rem;  // close the slot at the index, pulling entries from the right
  } shift_cmd_t;

endpackage

@@ sv/skt_channels.sv @@
// Valid/ready channel interfaces for requests and results of the table engine.
interface skt_req_if #(
  parameter int KEY_BITS    = 16,
  parameter int HANDLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic [skt_pkg::MODE_W-1:0]     mode;
  logic [KEY_BITS-1:0]           key;
  logic [HANDLE_BITS-1:0]        handle;
  logic [skt_pkg::POSITION_W-1:0] position;

  modport source (output valid, mode, key, handle, position, input ready);
  modport sink   (input valid, mode, key, handle, position, output ready);
endinterface

interface skt_rsp_if #(
  parameter int KEY_BITS    = 16,
  parameter int HANDLE_BITS = 16,
  parameter int COUNT_BITS  = 7
) ();
  logic                         valid;
  logic                         ready;
  logic [skt_pkg::STATUS_W-1:0] status;
  logic [COUNT_BITS-1:0]        found_index;
  logic [KEY_BITS-1:0]          key_out;
  logic [HANDLE_BITS-1:0]       handle_out;
  logic [COUNT_BITS-1:0]        entry_count;

  modport source (output valid, status, found_index, key_out, handle_out, entry_count,
                  input ready);
  modport sink   (input valid, status, found_index, key_out, handle_out, entry_count,
                  output ready);
endinterface

@@ sv/skt_cell.sv @@
// One table cell: holds a key and handle pair, compares and shifts with its neighbors.
module skt_cell #(
  parameter int KEY_BITS    = 16,
  parameter int HANDLE_BITS = 16,
  parameter int CNT_W       = 7,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  skt_pkg::shift_cmd_t    shift,
  input  logic [CNT_W-1:0]       shift_idx,
  input  logic [KEY_BITS-1:0]    new_key,
  input  logic [HANDLE_BITS-1:0] new_handle,
  input  logic [KEY_BITS-1:0]    left_key,
  input  logic [HANDLE_BITS-1:0] left_handle,
  input  logic [KEY_BITS-1:0]    right_key,
  input  logic [HANDLE_BITS-1:0] right_handle,
  input  logic [KEY_BITS-1:0]    cmp_key,
  input  logic [CNT_W-1:0]       sel,
  output logic [KEY_BITS-1:0]    key_q,
  output logic [HANDLE_BITS-1:0] handle_q,
  output logic                   eq_q,
  output logic                   gt_q,
  output logic [KEY_BITS-1:0]    rd_key,
  output logic [HANDLE_BITS-1:0] rd_handle
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic                   eq_r, gt_r;
  logic                   picked;

  // Next contents: shift right on insert, shift left on remove.
  always_comb begin
    key_nxt    = key_r;
    handle_nxt = handle_r;
    if (shift.ins) begin
      if (MY_IDX > shift_idx) begin
        key_nxt    = left_key;
        handle_nxt = left_handle;
      end else if (MY_IDX == shift_idx) begin
        key_nxt    = new_key;
        handle_nxt = new_handle;
      end
    end else if (shift.rem) begin
      if (MY_IDX >= shift_idx) begin
        key_nxt    = right_key;
        handle_nxt = right_handle;
      end
    end
  end

  // Entry storage and registered compare flags against the search key.
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
    eq_r     <= (key_r == cmp_key);
    gt_r     <= (key_r > cmp_key);
  end

  // Readout is masked so the row can be OR-combined.
  assign picked    = (MY_IDX == sel);
  assign rd_key    = picked ? key_r : '0;
  assign rd_handle = picked ? handle_r : '0;

  assign key_q    = key_r;
  assign handle_q = handle_r;
  assign eq_q     = eq_r;
  assign gt_q     = gt_r;

endmodule

@@ sv/sorted_key_table_engine.sv @@
// Top level of the sorted key table engine: sequencer, counters and the row of cells.
//
// Requests arrive as beats on in_ch (mode, key, handle, position); each request gives
// exactly one result beat on out_ch (status, found_index, key_out, handle_out,
// entry_count). Configuration (key order, unique keys) is written through cfg_we,
// cfg_index and cfg_data. The user must write it only while no request is in flight;
// the block does not enforce this. The table is a row of TABLE_DEPTH cells. Every cell
// compares its own key with the search key each cycle; the sequencer then runs a
// binary search over those compare flags, one probe per cycle, and inserts or deletes
// by shifting the cells from the found index onward one place toward their neighbor.
// One request is worked on at a time. After dispatch, clear, allocate id and requests
// refused without a search go straight to the result step; read by index and pop read
// the selected cell first; insert and lookups or deletes that miss search and then
// apply; lookups and deletes that hit also read the found cell after apply.
// in_ch.ready is high only while idle, so a new request beat is taken at the earliest
// when the previous result beat can leave. A finished result waits in an output
// register while out_ch.ready is low; the next request is still accepted and its
// result waits until the pending beat is taken.
// Reset empties the table, zeroes the id counter, selects ascending unique keys.
`include "sorted_key_table_engine_assert.svh"

module sorted_key_table_engine #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_BITS    = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  skt_req_if.sink                          in_ch,
  skt_rsp_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [skt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [skt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_APPLY,
    S_READ,
    S_RESULT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [KEY_BITS-1:0]      last_id_r, last_id_nxt;
  logic                     desc_r, desc_nxt;
  logic                     uniq_r, uniq_nxt;
  skt_pkg::mode_t           op_mode_r, op_mode_nxt;
  logic [KEY_BITS-1:0]      op_key_r, op_key_nxt;
  logic [HANDLE_BITS-1:0]   op_handle_r, op_handle_nxt;
  logic [skt_pkg::POSITION_W-1:0] op_pos_r, op_pos_nxt;
  logic [CNT_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         hp1_r, hp1_nxt;
  logic                     hit_r, hit_nxt;
  logic [CNT_W-1:0]         sel_r, sel_nxt;
  skt_pkg::result_code_t    res_status_r, res_status_nxt;
  logic [CNT_W-1:0]         res_idx_r, res_idx_nxt;
  logic [KEY_BITS-1:0]      res_key_r, res_key_nxt;
  logic [HANDLE_BITS-1:0]   res_handle_r, res_handle_nxt;
  logic                     out_valid_r, out_valid_nxt;
  skt_pkg::result_code_t    out_status_r, out_status_nxt;
  logic [CNT_W-1:0]         out_idx_r, out_idx_nxt;
  logic [KEY_BITS-1:0]      out_key_r, out_key_nxt;
  logic [HANDLE_BITS-1:0]   out_handle_r, out_handle_nxt;
  logic [CNT_W-1:0]         out_count_r, out_count_nxt;

  skt_pkg::shift_cmd_t      shift;
  logic [CNT_W:0]           mid_sum;
  logic [CNT_W-1:0]         mid;
  logic [KEY_BITS-1:0]      id_inc;
  logic                     in_fire;

  logic [KEY_BITS-1:0]      cell_key    [TABLE_DEPTH];
  logic [HANDLE_BITS-1:0]   cell_handle [TABLE_DEPTH];
  logic [KEY_BITS-1:0]      cell_rd_key [TABLE_DEPTH];
  logic [HANDLE_BITS-1:0]   cell_rd_hdl [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   eq_v;
  logic [TABLE_DEPTH-1:0]   gt_v;
  logic [KEY_BITS-1:0]      rd_key;
  logic [HANDLE_BITS-1:0]   rd_handle;

  // Row of cells wired to their neighbors; the first cell takes the new pair from the left.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]    lk, rk;
    logic [HANDLE_BITS-1:0] lh, rh;
    if (i == 0) begin : g_first
      assign lk = op_key_r;
      assign lh = op_handle_r;
    end else begin : g_left
      assign lk = cell_key[i-1];
      assign lh = cell_handle[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign rk = cell_key[i];
      assign rh = cell_handle[i];
    end else begin : g_right
      assign rk = cell_key[i+1];
      assign rh = cell_handle[i+1];
    end
    skt_cell #(
      .KEY_BITS    (KEY_BITS),
      .HANDLE_BITS (HANDLE_BITS),
      .CNT_W       (CNT_W),
      .INDEX       (i)
    ) u_cell (
      .clk          (clk),
      .shift        (shift),
      .shift_idx    (sel_r),
      .new_key      (op_key_r),
      .new_handle   (op_handle_r),
      .left_key     (lk),
      .left_handle  (lh),
      .right_key    (rk),
      .right_handle (rh),
      .cmp_key      (op_key_r),
      .sel          (sel_r),
      .key_q        (cell_key[i]),
      .handle_q     (cell_handle[i]),
      .eq_q         (eq_v[i]),
      .gt_q         (gt_v[i]),
      .rd_key       (cell_rd_key[i]),
      .rd_handle    (cell_rd_hdl[i])
    );
  end

  // Combine the masked readouts; only the selected cell contributes.
  always_comb begin
    rd_key    = '0;
    rd_handle = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      rd_key    = rd_key | cell_rd_key[i];
      rd_handle = rd_handle | cell_rd_hdl[i];
    end
  end

  // Probe position of the binary search: floor((lo + hi) / 2) with hi = hp1 - 1.
  assign mid_sum = {1'b0, lo_r} + {1'b0, hp1_r} - {{CNT_W{1'b0}}, 1'b1};
  assign mid     = mid_sum[CNT_W:1];

  assign id_inc  = last_id_r + {{(KEY_BITS-1){1'b0}}, 1'b1};
  assign in_fire = in_ch.valid && in_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_idx_r;
  assign out_ch.key_out     = out_key_r;
  assign out_ch.handle_out  = out_handle_r;
  assign out_ch.entry_count = out_count_r;

  // Sequencer: dispatch, search, apply, read and deliver one request at a time.
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    last_id_nxt    = last_id_r;
    desc_nxt       = desc_r;
    uniq_nxt       = uniq_r;
    op_mode_nxt    = op_mode_r;
    op_key_nxt     = op_key_r;
    op_handle_nxt  = op_handle_r;
    op_pos_nxt     = op_pos_r;
    lo_nxt         = lo_r;
    hp1_nxt        = hp1_r;
    hit_nxt        = hit_r;
    sel_nxt        = sel_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_key_nxt    = res_key_r;
    res_handle_nxt = res_handle_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_key_nxt    = out_key_r;
    out_handle_nxt = out_handle_r;
    out_count_nxt  = out_count_r;
    shift          = '0;

    // Configuration writes.
    if (cfg_we) begin
      case (cfg_index)
        skt_pkg::CFG_ORDER_DESC: desc_nxt = cfg_data[0];
        skt_pkg::CFG_UNIQUE:     uniq_nxt = cfg_data[0];
        default: ;
      endcase
    end

    // The result beat leaves when the receiver takes it.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_mode_nxt   = skt_pkg::mode_t'(in_ch.mode);
          op_key_nxt    = in_ch.key;
          op_handle_nxt = in_ch.handle;
          op_pos_nxt    = in_ch.position;
          state_nxt     = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_status_nxt = skt_pkg::ST_OK;
        res_idx_nxt    = '0;
        res_key_nxt    = '0;
        res_handle_nxt = '0;
        state_nxt      = S_RESULT;
        case (op_mode_r)
          skt_pkg::MODE_INSERT: begin
            lo_nxt    = '0;
            hp1_nxt   = fill_r;
            state_nxt = S_SEARCH;
          end
          skt_pkg::MODE_LOOKUP, skt_pkg::MODE_DELETE: begin
            if (op_key_r == '0) begin
              res_status_nxt = skt_pkg::ST_NOT_FOUND;
              res_key_nxt    = op_key_r;
            end else begin
              lo_nxt    = '0;
              hp1_nxt   = fill_r;
              state_nxt = S_SEARCH;
            end
          end
          skt_pkg::MODE_READ: begin
            if (32'(op_pos_r) >= 32'(fill_r)) begin
              res_status_nxt = skt_pkg::ST_BAD;
            end else begin
              sel_nxt   = CNT_W'(op_pos_r);
              state_nxt = S_READ;
            end
          end
          skt_pkg::MODE_POP: begin
            if (fill_r == '0) begin
              res_status_nxt = skt_pkg::ST_BAD;
            end else begin
              fill_nxt  = fill_r - {{(CNT_W-1){1'b0}}, 1'b1};
              sel_nxt   = fill_r - {{(CNT_W-1){1'b0}}, 1'b1};
              state_nxt = S_READ;
            end
          end
          skt_pkg::MODE_CLEAR: begin
            fill_nxt = '0;
          end
          skt_pkg::MODE_ALLOC: begin
            // The id counter wraps and never hands out zero.
            last_id_nxt = (id_inc == '0) ? {{(KEY_BITS-1){1'b0}}, 1'b1} : id_inc;
            res_key_nxt = (id_inc == '0) ? {{(KEY_BITS-1){1'b0}}, 1'b1} : id_inc;
          end
          default: begin
            res_status_nxt = skt_pkg::ST_BAD;
          end
        endcase
      end

      // One probe per cycle over the registered compare flags.
      S_SEARCH: begin
        if (lo_r >= hp1_r) begin
          hit_nxt   = 1'b0;
          sel_nxt   = lo_r;
          state_nxt = S_APPLY;
        end else if (eq_v[mid[IDX_W-1:0]]) begin
          hit_nxt   = 1'b1;
          sel_nxt   = mid;
          state_nxt = S_APPLY;
        end else if (gt_v[mid[IDX_W-1:0]] ^ desc_r) begin
          hp1_nxt = mid;
        end else begin
          lo_nxt = mid + {{(CNT_W-1){1'b0}}, 1'b1};
        end
      end

      S_APPLY: begin
        res_idx_nxt = sel_r;
        state_nxt   = S_RESULT;
        if (op_mode_r == skt_pkg::MODE_INSERT) begin
          if (hit_r && uniq_r) begin
            res_status_nxt = skt_pkg::ST_DUPLICATE;
          end else if (fill_r >= DEPTH_CNT) begin
            res_status_nxt = skt_pkg::ST_FULL;
          end else begin
            shift.ins      = 1'b1;
            fill_nxt       = fill_r + {{(CNT_W-1){1'b0}}, 1'b1};
            res_key_nxt    = op_key_r;
            res_handle_nxt = op_handle_r;
          end
        end else begin
          res_key_nxt = op_key_r;
          if (!hit_r) begin
            res_status_nxt = skt_pkg::ST_NOT_FOUND;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      // Selected cell is read out; delete closes the slot in the same cycle.
      S_READ: begin
        res_idx_nxt    = sel_r;
        res_handle_nxt = rd_handle;
        res_key_nxt    = rd_key;
        state_nxt      = S_RESULT;
        if (op_mode_r == skt_pkg::MODE_LOOKUP || op_mode_r == skt_pkg::MODE_DELETE) begin
          res_key_nxt = op_key_r;
        end
        if (op_mode_r == skt_pkg::MODE_DELETE) begin
          shift.rem = 1'b1;
          fill_nxt  = fill_r - {{(CNT_W-1){1'b0}}, 1'b1};
        end
      end

      S_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_key_nxt    = res_key_r;
          out_handle_nxt = res_handle_r;
          out_count_nxt  = fill_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, counters, configuration and registered outputs.
  always_ff @(posedge clk) begin
    op_mode_r    <= op_mode_nxt;
    op_key_r     <= op_key_nxt;
    op_handle_r  <= op_handle_nxt;
    op_pos_r     <= op_pos_nxt;
    lo_r         <= lo_nxt;
    hp1_r        <= hp1_nxt;
    hit_r        <= hit_nxt;
    sel_r        <= sel_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_key_r    <= res_key_nxt;
    res_handle_r <= res_handle_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_key_r    <= out_key_nxt;
    out_handle_r <= out_handle_nxt;
    out_count_r  <= out_count_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      last_id_r   <= '0;
      desc_r      <= 1'b0;
      uniq_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      last_id_r   <= last_id_nxt;
      desc_r      <= desc_nxt;
      uniq_r      <= uniq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A request beat always starts the dispatch step next.
  `SKT_ASSERT_NEXT(a_accept_dispatch, in_fire, state_r == S_DISPATCH,
                   "accepted request did not reach dispatch")
  // The cells never open a slot in a full table.
  `SKT_ASSERT_NOW(a_insert_room, shift.ins, fill_r < DEPTH_CNT,
                  "insert shift issued with a full table")
  // Closing a slot removes exactly one entry.
  `SKT_ASSERT_NEXT(a_remove_count, shift.rem,
                   fill_r == $past(fill_r) - {{(CNT_W-1){1'b0}}, 1'b1},
                   "remove shift did not decrement the fill level")

endmodule
